// ===== rtl/cbt_pkg.sv =====
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int NUM_CIRCUITS = 16;
  localparam int TIME_BITS    = 32;
  localparam int IDX_W        = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [15:0] FAIL_MAX = 16'hFFFF;
  localparam logic [7:0]  SUCC_MAX = 8'hFF;

  localparam logic [15:0] FAILURE_LIMIT_RST = 16'd5;
  localparam logic [7:0]  SUCCESS_LIMIT_RST = 8'd2;
  localparam logic [31:0] OPEN_TIMEOUT_RST  = 32'd60;

  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd0;
  localparam logic [1:0] REG_SUCCESS_LIMIT = 2'd1;
  localparam logic [1:0] REG_OPEN_TIMEOUT  = 2'd2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    OP_REQUEST     = 3'd0,
    OP_SUCCESS     = 3'd1,
    OP_FAILURE     = 3'd2,
    OP_FORCE_OPEN  = 3'd3,
    OP_FORCE_CLOSE = 3'd4,
    OP_RESET_ALL   = 3'd5,
    OP_READ_STATUS = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  // classified word handed from front to back
  typedef struct packed {
    op_t   op;
    logic  in_range;
    idx_t  idx;
    time_t now;
    time_t reopen;
  } cmd_t;

  typedef struct packed {
    logic [15:0] failure_limit;
    logic [7:0]  success_limit;
  } limits_t;

  typedef struct packed {
    logic        allowed;
    mode_t       circuit_state;
    logic [15:0] fail_total;
    logic [7:0]  success_total;
    logic        tripped;
  } result_t;

endpackage

// ===== rtl/cbt_front.sv =====
`timescale 1ns / 1ps

module cbt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [3:0]        in_circuit_id,
  input  logic [31:0]       in_now_time,
  input  logic [31:0]       open_timeout,
  output logic              q_valid,
  output cbt_pkg::cmd_t     q_word,
  input  logic              q_pop
);

  localparam int SUM_W = ((cbt_pkg::TIME_BITS > 32) ? cbt_pkg::TIME_BITS : 32) + 1;
  localparam int PTR_W = $clog2(cbt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cbt_pkg::QUEUE_DEPTH + 1);

  cbt_pkg::cmd_t         queue_r [cbt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  cbt_pkg::cmd_t         cmd;
  logic [SUM_W-1:0]      sum;
  logic                  push;
  logic                  pop;

  // classify the incoming word and precompute its reopen time
  always_comb begin
    cmd.now      = cbt_pkg::TIME_BITS'(in_now_time);
    cmd.idx      = cbt_pkg::IDX_W'(in_circuit_id);
    cmd.in_range = (32'(in_circuit_id) < cbt_pkg::NUM_CIRCUITS);
    if (in_operation > 3'(cbt_pkg::OP_READ_STATUS)) begin
      cmd.op = cbt_pkg::OP_READ_STATUS;
    end else begin
      cmd.op = cbt_pkg::op_t'(in_operation);
    end
    sum = SUM_W'(cmd.now) + SUM_W'(open_timeout);
    if (sum[SUM_W-1:cbt_pkg::TIME_BITS] != '0) begin
      cmd.reopen = '1;
    end else begin
      cmd.reopen = sum[cbt_pkg::TIME_BITS-1:0];
    end
  end

  assign busy    = (cnt_r == CNT_W'(cbt_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_word  = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(cbt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(cbt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cbt_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/cbt_back.sv =====
`timescale 1ns / 1ps

module cbt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cbt_pkg::cmd_t     q_word,
  output logic              q_pop,
  input  cbt_pkg::limits_t  limits,
  output logic              res_valid,
  output cbt_pkg::result_t  res
);

  cbt_pkg::mode_t   mode_r    [cbt_pkg::NUM_CIRCUITS];
  logic [15:0]      fail_r    [cbt_pkg::NUM_CIRCUITS];
  logic [7:0]       succ_r    [cbt_pkg::NUM_CIRCUITS];
  cbt_pkg::time_t   reopen_r  [cbt_pkg::NUM_CIRCUITS];

  logic              res_valid_r;
  cbt_pkg::result_t  res_r, res_nxt;

  cbt_pkg::mode_t   m, m_nxt;
  logic [15:0]      f, f_nxt, f_inc;
  logic [7:0]       s, s_nxt, s_inc;
  cbt_pkg::time_t   r, r_nxt;
  logic             allowed, tripped;
  logic             do_item;
  logic             clear_all;

  assign q_pop     = q_valid;
  assign do_item   = q_valid;
  assign clear_all = do_item && (q_word.op == cbt_pkg::OP_RESET_ALL);

  assign m = mode_r[q_word.idx];
  assign f = fail_r[q_word.idx];
  assign s = succ_r[q_word.idx];
  assign r = reopen_r[q_word.idx];

  assign f_inc = (f == cbt_pkg::FAIL_MAX) ? f : f + 16'd1;
  assign s_inc = (s == cbt_pkg::SUCC_MAX) ? s : s + 8'd1;

  always_comb begin
    m_nxt   = m;
    f_nxt   = f;
    s_nxt   = s;
    r_nxt   = r;
    allowed = 1'b0;
    tripped = 1'b0;
    unique case (q_word.op)
      cbt_pkg::OP_REQUEST: begin
        if (m == cbt_pkg::MODE_OPEN) begin
          if (q_word.now >= r) begin
            m_nxt   = cbt_pkg::MODE_HALF;
            s_nxt   = '0;
            allowed = 1'b1;
          end
        end else begin
          allowed = 1'b1;
        end
      end
      cbt_pkg::OP_SUCCESS: begin
        if (m == cbt_pkg::MODE_HALF) begin
          s_nxt = s_inc;
          if (s_inc >= limits.success_limit) begin
            m_nxt = cbt_pkg::MODE_CLOSED;
            f_nxt = '0;
            s_nxt = '0;
          end
        end else if (m == cbt_pkg::MODE_CLOSED) begin
          f_nxt = '0;
        end
      end
      cbt_pkg::OP_FAILURE: begin
        f_nxt = f_inc;
        if (m == cbt_pkg::MODE_HALF) begin
          m_nxt = cbt_pkg::MODE_OPEN;
          r_nxt = q_word.reopen;
          s_nxt = '0;
        end else if (m == cbt_pkg::MODE_CLOSED && f_inc >= limits.failure_limit) begin
          m_nxt   = cbt_pkg::MODE_OPEN;
          r_nxt   = q_word.reopen;
          tripped = 1'b1;
        end
      end
      cbt_pkg::OP_FORCE_OPEN: begin
        m_nxt = cbt_pkg::MODE_OPEN;
        r_nxt = q_word.reopen;
      end
      cbt_pkg::OP_FORCE_CLOSE: begin
        m_nxt = cbt_pkg::MODE_CLOSED;
        f_nxt = '0;
        s_nxt = '0;
      end
      cbt_pkg::OP_RESET_ALL: begin
        m_nxt = cbt_pkg::MODE_CLOSED;
        f_nxt = '0;
        s_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (q_word.in_range) begin
      res_nxt.allowed       = allowed;
      res_nxt.circuit_state = m_nxt;
      res_nxt.fail_total    = f_nxt;
      res_nxt.success_total = s_nxt;
      res_nxt.tripped       = tripped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbt_pkg::NUM_CIRCUITS; i++) begin
        mode_r[i]   <= cbt_pkg::MODE_CLOSED;
        fail_r[i]   <= '0;
        succ_r[i]   <= '0;
        reopen_r[i] <= '0;
      end
    end else if (clear_all) begin
      // reopen times survive a reset-all
      for (int i = 0; i < cbt_pkg::NUM_CIRCUITS; i++) begin
        mode_r[i] <= cbt_pkg::MODE_CLOSED;
        fail_r[i] <= '0;
        succ_r[i] <= '0;
      end
    end else if (do_item && q_word.in_range) begin
      mode_r[q_word.idx]   <= m_nxt;
      fail_r[q_word.idx]   <= f_nxt;
      succ_r[q_word.idx]   <= s_nxt;
      reopen_r[q_word.idx] <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= do_item;
    end
  end

  always_ff @(posedge clk) begin
    if (do_item) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef SYNTH
  a_pop_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |=> res_valid_r)
    else $error("popped word produced no result");
  a_trip_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.tripped) |-> (res_r.circuit_state == cbt_pkg::MODE_OPEN))
    else $error("trip without open state");
  a_allow_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.allowed) |-> (res_r.circuit_state != cbt_pkg::MODE_OPEN))
    else $error("request allowed on open circuit");
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |=> !res_valid_r)
    else $error("result without popped word");
`endif

endmodule

// ===== rtl/circuit_breaker_table_core.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                   | Handshake
// input    | in_operation, in_circuit_id, in_now_time | taken when start && !busy
// result   | out_allowed .. out_tripped              | out_valid for one cycle
// config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One word per cycle while busy is low; a taken word passes through the queue and then
// the result registers, which raise out_valid.
// The rate is set by the read-modify-write of the breaker table in the back end;
// reset-all clears the mode and counts of every entry there but keeps reopen times.
// A two-word queue parts front and back; busy is raised only when it is full.
// Reset (rst_n low, synchronous) closes all entries and loads default limits.
// Results cannot be stalled by the receiver.

module circuit_breaker_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_circuit_id,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  output logic        out_allowed,
  output logic [1:0]  out_circuit_state,
  output logic [15:0] out_fail_total,
  output logic [7:0]  out_success_total,
  output logic        out_tripped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]       failure_limit_r;
  logic [7:0]        success_limit_r;
  logic [31:0]       open_timeout_r;
  logic              cfg_wr;

  logic              q_valid;
  logic              q_pop;
  cbt_pkg::cmd_t     q_word;
  cbt_pkg::limits_t  limits;
  logic              res_valid;
  cbt_pkg::result_t  res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failure_limit_r <= cbt_pkg::FAILURE_LIMIT_RST;
      success_limit_r <= cbt_pkg::SUCCESS_LIMIT_RST;
      open_timeout_r  <= cbt_pkg::OPEN_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        cbt_pkg::REG_FAILURE_LIMIT: failure_limit_r <= pwdata[15:0];
        cbt_pkg::REG_SUCCESS_LIMIT: success_limit_r <= pwdata[7:0];
        cbt_pkg::REG_OPEN_TIMEOUT:  open_timeout_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cbt_pkg::REG_FAILURE_LIMIT: prdata = 32'(failure_limit_r);
      cbt_pkg::REG_SUCCESS_LIMIT: prdata = 32'(success_limit_r);
      cbt_pkg::REG_OPEN_TIMEOUT:  prdata = open_timeout_r;
      default:                    prdata = '0;
    endcase
  end

  assign limits.failure_limit = failure_limit_r;
  assign limits.success_limit = success_limit_r;

  cbt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_circuit_id (in_circuit_id),
    .in_now_time   (in_now_time),
    .open_timeout  (open_timeout_r),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop)
  );

  cbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .limits    (limits),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid         = res_valid;
  assign out_allowed       = res.allowed;
  assign out_circuit_state = res.circuit_state;
  assign out_fail_total    = res.fail_total;
  assign out_success_total = res.success_total;
  assign out_tripped       = res.tripped;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_SPARE   = 3'd7;  // unused code, acts as read status
  localparam int         IDLE_LIMIT = 5000;
  localparam int         SETTLE     = 6;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [3:0]  in_circuit_id;
  logic [31:0] in_now_time;
  logic        out_valid;
  logic        out_allowed;
  logic [1:0]  out_circuit_state;
  logic [15:0] out_fail_total;
  logic [7:0]  out_success_total;
  logic        out_tripped;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  circuit_breaker_table_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_circuit_id(in_circuit_id),
    .in_now_time(in_now_time),
    .out_valid(out_valid),
    .out_allowed(out_allowed),
    .out_circuit_state(out_circuit_state),
    .out_fail_total(out_fail_total),
    .out_success_total(out_success_total),
    .out_tripped(out_tripped),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // breaker table as the testbench sees it
  cbt_pkg::mode_t mode_tab [cbt_pkg::NUM_CIRCUITS];
  logic [15:0]    fail_tab [cbt_pkg::NUM_CIRCUITS];
  logic [7:0]     succ_tab [cbt_pkg::NUM_CIRCUITS];
  logic [31:0]    reopen_tab [cbt_pkg::NUM_CIRCUITS];
  logic [15:0]    fail_limit_cfg;
  logic [7:0]     succ_limit_cfg;
  logic [31:0]    timeout_cfg;

  cbt_pkg::result_t breaker_status_q[$];
  cbt_pkg::result_t head_status;
  int          mismatches;
  int          words_sent;
  int          results_checked;
  int          cfg_writes;
  int          idle_cycles;
  bit          gaps_on;
  logic [31:0] cur_time;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] reopen_after(input logic [31:0] now);
    logic [32:0] sum;
    sum = {1'b0, now} + {1'b0, timeout_cfg};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic cbt_pkg::result_t step_breaker(input logic [2:0] op,
                                                    input logic [3:0] cid,
                                                    input logic [31:0] now);
    cbt_pkg::result_t r;
    r = '0;
    if (op == cbt_pkg::OP_RESET_ALL) begin
      for (int i = 0; i < cbt_pkg::NUM_CIRCUITS; i++) begin
        mode_tab[i] = cbt_pkg::MODE_CLOSED;
        fail_tab[i] = '0;
        succ_tab[i] = '0;
      end
    end
    case (op)
      cbt_pkg::OP_REQUEST: begin
        if (mode_tab[cid] == cbt_pkg::MODE_OPEN) begin
          if (now >= reopen_tab[cid]) begin
            mode_tab[cid] = cbt_pkg::MODE_HALF;
            succ_tab[cid] = '0;
            r.allowed = 1'b1;
          end
        end else begin
          r.allowed = 1'b1;
        end
      end
      cbt_pkg::OP_SUCCESS: begin
        if (mode_tab[cid] == cbt_pkg::MODE_HALF) begin
          if (succ_tab[cid] < cbt_pkg::SUCC_MAX) succ_tab[cid]++;
          if (succ_tab[cid] >= succ_limit_cfg) begin
            mode_tab[cid] = cbt_pkg::MODE_CLOSED;
            fail_tab[cid] = '0;
            succ_tab[cid] = '0;
          end
        end else if (mode_tab[cid] == cbt_pkg::MODE_CLOSED) begin
          fail_tab[cid] = '0;
        end
      end
      cbt_pkg::OP_FAILURE: begin
        if (fail_tab[cid] < cbt_pkg::FAIL_MAX) fail_tab[cid]++;
        if (mode_tab[cid] == cbt_pkg::MODE_HALF) begin
          mode_tab[cid] = cbt_pkg::MODE_OPEN;
          reopen_tab[cid] = reopen_after(now);
          succ_tab[cid] = '0;
        end else if (mode_tab[cid] == cbt_pkg::MODE_CLOSED &&
                     fail_tab[cid] >= fail_limit_cfg) begin
          mode_tab[cid] = cbt_pkg::MODE_OPEN;
          reopen_tab[cid] = reopen_after(now);
          r.tripped = 1'b1;
        end
      end
      cbt_pkg::OP_FORCE_OPEN: begin
        mode_tab[cid] = cbt_pkg::MODE_OPEN;
        reopen_tab[cid] = reopen_after(now);
      end
      cbt_pkg::OP_FORCE_CLOSE: begin
        mode_tab[cid] = cbt_pkg::MODE_CLOSED;
        fail_tab[cid] = '0;
        succ_tab[cid] = '0;
      end
      default: ;
    endcase
    r.circuit_state = mode_tab[cid];
    r.fail_total    = fail_tab[cid];
    r.success_total = succ_tab[cid];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one word; start stays high on return unless a gap follows
  task automatic send_word(input logic [2:0] op, input logic [3:0] cid,
                           input logic [31:0] now);
    int gap;
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_circuit_id <= cid;
    in_now_time   <= now;
    do @(posedge clk); while (busy);
    breaker_status_q.push_back(step_breaker(op, cid, now));
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (breaker_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write, then read back over the same port
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    logic [31:0] mask;
    case (reg_idx)
      cbt_pkg::REG_FAILURE_LIMIT: mask = 32'h0000_FFFF;
      cbt_pkg::REG_SUCCESS_LIMIT: mask = 32'h0000_00FF;
      default:                    mask = 32'hFFFF_FFFF;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      cbt_pkg::REG_FAILURE_LIMIT: fail_limit_cfg = value[15:0];
      cbt_pkg::REG_SUCCESS_LIMIT: succ_limit_cfg = value[7:0];
      default:                    timeout_cfg    = value;
    endcase
    cfg_writes++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (value & mask))
      report_mismatch("register readback", prdata & mask, value & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] fl, input logic [7:0] sl,
                            input logic [31:0] tmo);
    wait_idle();
    cfg_write(cbt_pkg::REG_FAILURE_LIMIT, {16'h0, fl});
    cfg_write(cbt_pkg::REG_SUCCESS_LIMIT, {24'h0, sl});
    cfg_write(cbt_pkg::REG_OPEN_TIMEOUT, tmo);
  endtask

  // default limits 5 / 2 / 60: full closed -> open -> half-open -> closed cycle
  task automatic test_default_cycle();
    send_word(cbt_pkg::OP_READ_STATUS, 4'd0, 32'd100);
    send_word(cbt_pkg::OP_REQUEST, 4'd0, 32'd100);
    for (int i = 0; i < 5; i++) send_word(cbt_pkg::OP_FAILURE, 4'd0, 32'd100 + i);
    send_word(cbt_pkg::OP_REQUEST, 4'd0, 32'd163);   // one unit early
    send_word(cbt_pkg::OP_REQUEST, 4'd0, 32'd164);   // due exactly
    send_word(cbt_pkg::OP_SUCCESS, 4'd0, 32'd165);
    send_word(cbt_pkg::OP_FAILURE, 4'd0, 32'd170);   // half-open falls back to open
    send_word(cbt_pkg::OP_REQUEST, 4'd0, 32'd230);
    send_word(cbt_pkg::OP_SUCCESS, 4'd0, 32'd231);
    send_word(cbt_pkg::OP_SUCCESS, 4'd0, 32'd232);
    send_word(cbt_pkg::OP_FAILURE, 4'd1, 32'd233);
    send_word(cbt_pkg::OP_SUCCESS, 4'd1, 32'd234);   // clears closed failure count
    send_word(cbt_pkg::OP_FORCE_OPEN, 4'd2, 32'd240);
    send_word(cbt_pkg::OP_SUCCESS, 4'd2, 32'd241);   // open entry ignores success
    send_word(cbt_pkg::OP_FORCE_CLOSE, 4'd2, 32'd242);
    send_word(cbt_pkg::OP_FAILURE, 4'd3, 32'd243);
    send_word(cbt_pkg::OP_FORCE_OPEN, 4'd3, 32'd244);
    send_word(cbt_pkg::OP_RESET_ALL, 4'd3, 32'd245);
    send_word(OP_SPARE, 4'd3, 32'd246);
    send_word(cbt_pkg::OP_FORCE_OPEN, 4'd15, 32'hFFFF_FFF0);  // reopen time saturates
    send_word(cbt_pkg::OP_REQUEST, 4'd15, 32'hFFFF_FFFE);
    send_word(cbt_pkg::OP_REQUEST, 4'd15, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_limits();
    set_limits(16'd0, 8'd0, 32'd0);
    send_word(cbt_pkg::OP_FAILURE, 4'd4, 32'd10);    // trips on first failure
    send_word(cbt_pkg::OP_REQUEST, 4'd4, 32'd10);    // zero timeout, due at once
    send_word(cbt_pkg::OP_SUCCESS, 4'd4, 32'd11);    // closes on first success
    send_word(cbt_pkg::OP_FORCE_OPEN, 4'd4, 32'd12);
    send_word(cbt_pkg::OP_REQUEST, 4'd4, 32'd12);
    send_word(cbt_pkg::OP_FAILURE, 4'd4, 32'd13);
    send_word(cbt_pkg::OP_READ_STATUS, 4'd4, 32'd14);
  endtask

  task automatic test_limit_extremes();
    set_limits(16'd1, 8'd255, 32'hFFFF_FFFF);
    send_word(cbt_pkg::OP_FORCE_OPEN, 4'd6, 32'd5);
    send_word(cbt_pkg::OP_REQUEST, 4'd6, 32'd1000);
    send_word(cbt_pkg::OP_REQUEST, 4'd6, 32'hFFFF_FFFF);
    for (int i = 0; i < 255; i++) send_word(cbt_pkg::OP_SUCCESS, 4'd6, 32'hFFFF_FFFF);
    send_word(cbt_pkg::OP_FAILURE, 4'd6, 32'd0);
  endtask

  // failure count climbs under the top limit without tripping
  task automatic test_high_failure_limit();
    set_limits(16'hFFFF, 8'd2, 32'd60);
    gaps_on = 1'b0;
    send_word(cbt_pkg::OP_FORCE_CLOSE, 4'd7, 32'd0);
    for (int i = 0; i < 20; i++) send_word(cbt_pkg::OP_FAILURE, 4'd7, 32'd50);
    send_word(cbt_pkg::OP_SUCCESS, 4'd7, 32'd60);
    gaps_on = 1'b1;
  endtask

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return cbt_pkg::OP_REQUEST;
    if (r < 48) return cbt_pkg::OP_SUCCESS;
    if (r < 76) return cbt_pkg::OP_FAILURE;
    if (r < 82) return cbt_pkg::OP_FORCE_OPEN;
    if (r < 88) return cbt_pkg::OP_FORCE_CLOSE;
    if (r < 91) return cbt_pkg::OP_RESET_ALL;
    if (r < 97) return cbt_pkg::OP_READ_STATUS;
    return OP_SPARE;
  endfunction

  task automatic run_random_phase(input logic [15:0] fl, input logic [7:0] sl,
                                  input logic [31:0] tmo, input logic [31:0] t0,
                                  input int count, input bit with_gaps);
    int r;
    logic [3:0] cid;
    set_limits(fl, sl, tmo);
    gaps_on  = with_gaps;
    cur_time = t0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) cur_time = $urandom;
      else if (r < 8) cur_time += $urandom_range(50, 400);
      else cur_time += $urandom_range(0, 12);
      // most traffic on a few circuits so sequences build up
      cid = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      send_word(pick_op(), cid, cur_time);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'($urandom_range(1, 6)), 8'($urandom_range(1, 3)),
                     $urandom_range(0, 40), 32'd0, 240, 1'b1);
    run_random_phase(16'd1, 8'd1, 32'd0, 32'h0001_0000, 240, 1'b0);
    run_random_phase(16'hFFFF, 8'd255, 32'hFFFF_FFFF, 32'h8000_0000, 240, 1'b1);
    run_random_phase(16'($urandom_range(2, 4)), 8'($urandom_range(2, 5)),
                     $urandom_range(10, 200), 32'hFFFF_F000, 240, 1'b1);
    run_random_phase(16'd0, 8'd0, $urandom, 32'h00FF_0000, 240, 1'b1);
    run_random_phase(16'd3, 8'd2, 32'd20, 32'h1234_5678, 240, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (breaker_status_q.size() == 0) begin
        report_mismatch("result with no word pending", 32'h1, 32'h0);
      end else begin
        head_status = breaker_status_q.pop_front();
        results_checked++;
        if (out_allowed !== head_status.allowed)
          report_mismatch("allowed", 32'(out_allowed), 32'(head_status.allowed));
        if (out_circuit_state !== head_status.circuit_state)
          report_mismatch("circuit_state", 32'(out_circuit_state),
                          32'(head_status.circuit_state));
        if (out_fail_total !== head_status.fail_total)
          report_mismatch("fail_total", 32'(out_fail_total), 32'(head_status.fail_total));
        if (out_success_total !== head_status.success_total)
          report_mismatch("success_total", 32'(out_success_total),
                          32'(head_status.success_total));
        if (out_tripped !== head_status.tripped)
          report_mismatch("tripped", 32'(out_tripped), 32'(head_status.tripped));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d results still pending",
                 idle_cycles, breaker_status_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = cbt_pkg::OP_READ_STATUS;
    in_circuit_id   = '0;
    in_now_time     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    cfg_writes      = 0;
    idle_cycles     = 0;
    gaps_on         = 1'b1;
    cur_time        = '0;
    for (int i = 0; i < cbt_pkg::NUM_CIRCUITS; i++) begin
      mode_tab[i]   = cbt_pkg::MODE_CLOSED;
      fail_tab[i]   = '0;
      succ_tab[i]   = '0;
      reopen_tab[i] = '0;
    end
    fail_limit_cfg = cbt_pkg::FAILURE_LIMIT_RST;
    succ_limit_cfg = cbt_pkg::SUCCESS_LIMIT_RST;
    timeout_cfg    = cbt_pkg::OPEN_TIMEOUT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_cycle();
    test_zero_limits();
    test_limit_extremes();
    test_high_failure_limit();
    test_random_traffic();
    wait_idle();

    $display("ran %0d words through %0d register writes; %0d results checked",
             words_sent, cfg_writes, results_checked);
    $display("covered every operation, zero and extreme limits, success count at its top");
    $display("value and saturated reopen times");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
